### design/mwpo_pkg.sv
// Package for the multi-waveform phase oscillator: field widths, constants,
// waveform codes, control structs and the quarter-wave sine generator.
// No dependencies.
package mwpo_pkg;

  // Default sizes of the sine table and the phase accumulator
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  // Request and result field widths
  localparam int MODE_W   = 3;
  localparam int FREQ_W   = 24;
  localparam int PM_W     = 15;
  localparam int SAMPLE_W = 16;
  localparam int SINE_W   = 15;

  // Configuration port
  localparam int CFG_W   = 32;
  localparam int PADDR_W = 3;
  localparam logic REG_IDX_PPFU = 1'b0;
  localparam logic [CFG_W-1:0] PPFU_RESET = 32'd22906492;

  // Pulse modulation clamp and scale (1/256 percent units)
  localparam logic [PM_W-1:0] PM_LOW  = 15'd256;
  localparam logic [PM_W-1:0] PM_HIGH = 15'd25344;
  localparam int PM_UNIT_W = 14;
  localparam logic [PM_UNIT_W-1:0] PM_UNIT = 14'd12800;
  localparam logic [PM_UNIT_W-1:0] PM_HALF = 14'd6400;

  // Serial arithmetic sizes
  localparam int MCAND_W    = 32;                  // widest multiplicand
  localparam int MPLR_W     = 24;                  // multiplier shift register
  localparam int PROD_W     = MCAND_W + MPLR_W;    // full product
  localparam int PM_PROD_W  = FREQ_W + PM_W;       // magnitude times pulse_mod
  localparam int RND_BITS   = 16;                  // fraction bits of the increment
  localparam int INC_HI_W   = PROD_W - RND_BITS;
  localparam int MULPM_STEPS = PM_W;
  localparam int DIV_STEPS   = MPLR_W;
  localparam int MULF_STEPS  = MPLR_W;
  localparam int CNT_W       = 5;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Waveform codes
  typedef enum logic [MODE_W-1:0] {
    MODE_SINE   = 3'd0,
    MODE_SQUARE = 3'd1,
    MODE_PWM    = 3'd2,
    MODE_SAWDN  = 3'd3,
    MODE_SAWUP  = 3'd4,
    MODE_TRI    = 3'd5
  } mode_e;

  // Commands to and status from the increment unit
  typedef struct packed {
    logic start;
    logic pwm;
    logic ack;
  } incr_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } incr_stat_t;

  // sin(pi/2 * k / 2^tbits) in Q0.15 by a fixed-point Taylor series;
  // evaluated at elaboration only to fill the quarter-wave table
  function automatic logic [SINE_W-1:0] sine_q15(input int unsigned k,
                                                 input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    logic signed [63:0] sum;
    x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tbits - 1))) >> tbits;
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage

### design/mwpo_incr.sv
// Bit-serial phase increment unit: optional pulse_mod scaling (multiply,
// round, divide by 12800) then the multiply by the phase-per-unit register.
// Depends on mwpo_pkg.
module mwpo_incr import mwpo_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  incr_cmd_t             cmd_i,
  input  logic [FREQ_W-1:0]     mag_i,
  input  logic [PM_W-1:0]       pm_i,
  input  logic [CFG_W-1:0]      ppfu_i,
  output incr_stat_t            stat_o,
  output logic [PHASE_BITS-1:0] inc_o,
  output logic                  rnd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MULPM = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MULF  = 6'b010000,
    ST_DONE  = 6'b100000
  } incr_state_e;

  incr_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [MCAND_W-1:0] mcand_q, mcand_d;
  logic [MCAND_W-1:0] hi_q, hi_d;
  logic [MPLR_W-1:0]  lo_q, lo_d;

  logic [PM_W-1:0]      pm_clamped;
  logic [MCAND_W:0]     step_sum;
  logic [PM_PROD_W-1:0] pm_dividend;
  logic [PM_UNIT_W:0]   div_rem;
  logic [PM_UNIT_W:0]   div_sub;
  logic                 div_ge;
  logic [PROD_W-1:0]    prod;

  // Clamp pulse_mod to 1%..99%
  always_comb begin
    pm_clamped = pm_i;
    if (pm_i < PM_LOW) begin
      pm_clamped = PM_LOW;
    end else if (pm_i > PM_HIGH) begin
      pm_clamped = PM_HIGH;
    end
  end

  // One shift-add step: add the multiplicand when the next multiplier bit is set
  assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  // Rounded dividend for the pulse_mod scaling
  assign pm_dividend = {hi_q[FREQ_W-1:0], lo_q[MPLR_W-1 -: PM_W]} + PM_PROD_W'(PM_HALF);

  // One restoring division step by the constant unit
  assign div_rem = {hi_q[PM_UNIT_W-1:0], lo_q[MPLR_W-1]};
  assign div_ge  = (div_rem >= {1'b0, PM_UNIT});
  assign div_sub = div_rem - {1'b0, PM_UNIT};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          hi_d = '0;
          if (cmd_i.pwm) begin
            mcand_d = MCAND_W'(mag_i);
            lo_d    = MPLR_W'(pm_clamped);
            cnt_d   = CNT_W'(MULPM_STEPS - 1);
            state_d = ST_MULPM;
          end else begin
            mcand_d = ppfu_i;
            lo_d    = mag_i;
            cnt_d   = CNT_W'(MULF_STEPS - 1);
            state_d = ST_MULF;
          end
        end
      end
      ST_MULPM: begin
        hi_d  = step_sum[MCAND_W:1];
        lo_d  = {step_sum[0], lo_q[MPLR_W-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // Split the dividend: top bits seed the remainder, the rest shift in
        hi_d    = MCAND_W'(pm_dividend[PM_PROD_W-2:MPLR_W]);
        lo_d    = pm_dividend[MPLR_W-1:0];
        cnt_d   = CNT_W'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        lo_d  = {lo_q[MPLR_W-2:0], div_ge};
        hi_d  = MCAND_W'(div_ge ? div_sub[PM_UNIT_W-1:0] : div_rem[PM_UNIT_W-1:0]);
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // Quotient stays in place as the next multiplier
          hi_d    = '0;
          mcand_d = ppfu_i;
          cnt_d   = CNT_W'(MULF_STEPS - 1);
          state_d = ST_MULF;
        end
      end
      ST_MULF: begin
        hi_d  = step_sum[MCAND_W:1];
        lo_d  = {step_sum[0], lo_q[MPLR_W-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (cmd_i.ack) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  // Product split: integer part of the increment and the rounding bit
  assign prod  = {hi_q, lo_q};
  assign rnd_o = prod[RND_BITS-1];

  if (PHASE_BITS <= INC_HI_W) begin : g_inc_trunc
    assign inc_o = prod[RND_BITS +: PHASE_BITS];
  end else begin : g_inc_ext
    assign inc_o = {{(PHASE_BITS - INC_HI_W){1'b0}}, prod[PROD_W-1:RND_BITS]};
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);

endmodule

### design/multi_waveform_phase_oscillator_unit.sv
// Channel    Handshake               Payload
// request    in_valid_i/in_ready_o   mode_i, frequency_i, pulse_mod_i
// result     out_valid_o/out_ready_i sample_o
// config     psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One request at a time. The bit-serial increment unit spends one cycle per
// multiplier bit and one per quotient bit: the pulse_mod multiply, rounding and
// divide run for pwm requests only, then the phase-per-unit multiply for all.
// The result register lets the next request enter while a sample waits; the
// phase advances only when its sample is written. Reset clears the phase and
// loads the phase-per-unit register with its 48 kHz value; no clearing pass.
module multi_waveform_phase_oscillator_unit import mwpo_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [MODE_W-1:0]          mode_i,
  input  logic signed [FREQ_W-1:0]   frequency_i,
  input  logic [PM_W-1:0]            pulse_mod_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [CFG_W-1:0]           pwdata,
  output logic [CFG_W-1:0]           prdata,
  output logic                       pready
);

  localparam int SINE_N = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W = SINE_TABLE_BITS + 1;

  logic                       busy_q;
  mode_e                      mode_q;
  logic                       neg_q;
  logic [PHASE_BITS-1:0]      phase_q;
  logic [CFG_W-1:0]           ppfu_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic [SINE_W-1:0]          rom_q;

  logic                  in_fire;
  logic                  upd;
  logic [FREQ_W-1:0]     freq_bits;
  logic [FREQ_W-1:0]     mag;
  incr_cmd_t             cmd;
  incr_stat_t            stat;
  logic [PHASE_BITS-1:0] inc;
  logic                  rnd;
  logic                  carry_in;
  logic [PHASE_BITS-1:0] phase_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppfu_q <= PPFU_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_PPFU)) begin
      ppfu_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_PPFU) ? ppfu_q : '0;

  // Request intake
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign freq_bits  = frequency_i;
  assign mag        = freq_bits[FREQ_W-1] ? (~freq_bits + 1'b1) : freq_bits;

  assign upd       = stat.done && (!out_valid_q || out_ready_i);
  assign cmd.start = in_fire;
  assign cmd.pwm   = (mode_i == MODE_PWM);
  assign cmd.ack   = upd;

  mwpo_incr #(
    .PHASE_BITS(PHASE_BITS)
  ) u_incr (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .mag_i (mag),
    .pm_i  (pulse_mod_i),
    .ppfu_i(ppfu_q),
    .stat_o(stat),
    .inc_o (inc),
    .rnd_o (rnd)
  );

  // Quarter-wave sine table
  logic [SINE_W-1:0] sine_rom [SINE_N+1];

  for (genvar k = 0; k <= SINE_N; k++) begin : g_rom
    localparam logic [SINE_W-1:0] RomVal = sine_q15(k, SINE_TABLE_BITS);
    assign sine_rom[k] = RomVal;
  end

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ADDR_W-1:0]          rom_addr;

  assign quad     = phase_q[PHASE_BITS-1 -: 2];
  assign idx      = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (ADDR_W'(SINE_N) - {1'b0, idx}) : {1'b0, idx};

  // Track the table entry for the current phase
  always_ff @(posedge clk_i) begin
    rom_q <= sine_rom[rom_addr];
  end

  // Waveform from the phase before the advance
  logic [SAMPLE_W-1:0] t;
  logic [SAMPLE_W-1:0] saw_up;
  logic [SAMPLE_W-1:0] saw_dn;
  logic [SAMPLE_W-1:0] tri_mag;
  logic [SAMPLE_W-1:0] tri_wave;
  logic [SAMPLE_W-1:0] sine_pos;
  logic [SAMPLE_W-1:0] sine_wave;
  logic                le_half;

  assign t        = phase_q[PHASE_BITS-1 -: SAMPLE_W];
  assign saw_up   = {~t[SAMPLE_W-1], t[SAMPLE_W-2:0]};
  assign saw_dn   = (saw_up == 16'h8000) ? 16'h7FFF : (~saw_up + 1'b1);
  assign tri_mag  = saw_up[SAMPLE_W-1] ? (~saw_up + 1'b1) : saw_up;
  assign tri_wave = tri_mag[SAMPLE_W-1] ? 16'h7FFF
                                        : {~tri_mag[SAMPLE_W-2], tri_mag[SAMPLE_W-3:0], 1'b0};
  assign sine_pos  = {1'b0, rom_q};
  assign sine_wave = quad[1] ? (~sine_pos + 1'b1) : sine_pos;
  assign le_half   = !phase_q[PHASE_BITS-1] || (phase_q[PHASE_BITS-2:0] == '0);

  always_comb begin
    case (mode_q)
      MODE_SINE:   sample_d = signed'(sine_wave);
      MODE_SQUARE,
      MODE_PWM:    sample_d = le_half ? 16'sh7FFF : 16'sh8000;
      MODE_SAWDN:  sample_d = signed'(saw_dn);
      MODE_SAWUP:  sample_d = signed'(saw_up);
      MODE_TRI:    sample_d = signed'(tri_wave);
      default:     sample_d = '0;
    endcase
  end

  // Advance or retreat the phase; the carry-in folds in the rounding bit
  assign carry_in = neg_q ^ rnd;
  assign phase_d  = phase_q + (neg_q ? ~inc : inc) + PHASE_BITS'(carry_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (upd) begin
        busy_q <= 1'b0;
      end
      if (upd) begin
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold request fields and the result sample
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= mode_e'(mode_i);
      neg_q  <= frequency_i[FREQ_W-1];
    end
    if (upd) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

### design/mwpo_checker.sv
// Port-level checks for the oscillator top level, attached by bind.
// Depends on mwpo_pkg and multi_waveform_phase_oscillator_unit.
module mwpo_checker import mwpo_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] sample_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [PADDR_W-1:0]         paddr,
  input logic [CFG_W-1:0]           pwdata,
  input logic [CFG_W-1:0]           prdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o))
    else $error("result changed while stalled");

  // Drop ready once a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // No result appears the cycle after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Read back what was written
  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_IDX_PPFU)
    |=> (paddr[2] != REG_IDX_PPFU) || (prdata == $past(pwdata)))
    else $error("register readback mismatch");

endmodule

bind multi_waveform_phase_oscillator_unit mwpo_checker u_mwpo_checker (.*);
